// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/tin_pkg.sv =====
// Shared types and constants of the text input normalizer.
`default_nettype none

package tin_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_DATA  = 2'd0;
   localparam kind_type KIND_END   = 2'd1;
   localparam kind_type KIND_ERROR = 2'd2;
   localparam kind_type KIND_BAD   = 2'd3;
   localparam kind_type STAT_OPEN  = 2'd0;

   localparam logic [7:0] CH_HT = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] BOM_A = 8'hef;
   localparam logic [7:0] BOM_B = 8'hbb;
   localparam logic [7:0] BOM_C = 8'hbf;

   localparam logic [31:0] RUN_MAX_DEF   = 32'd65535;
   localparam int          LINE_BITS_DEF = 32;
   localparam int          QUEUE_DEPTH   = 4;

   // One queued work entry: up to three bytes, then an optional mark.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      nbytes;
      kind_type        tail;    // KIND_DATA means no mark
      logic            bom;
   } op_type;

   // One result word.
   typedef struct packed {
      logic [7:0]  data;
      kind_type    kind;
      logic [15:0] count;
      logic [31:0] line;
      logic        bom;
   } res_type;

endpackage

`default_nettype wire

// ===== hdl/tin_front.sv =====
// Front end: accepts raw words, handles the leading BOM window, builds queue entries.
`default_nettype none

module tin_front import tin_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_raw_byte,
   input  logic [1:0] req_raw_kind,
   input  logic       q_full,
   output logic       push,
   output op_type     push_op
);

   logic       lead_done_ff, lead_done_in;
   logic [1:0] lead_cnt_ff, lead_cnt_in;
   logic       bom_ff, bom_in;
   logic [7:0] buf0_ff, buf1_ff;
   logic       accept;
   kind_type   kind;
   logic       bom_match;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign kind      = (req_raw_kind == KIND_BAD) ? KIND_ERROR : req_raw_kind;
   assign bom_match = (buf0_ff == BOM_A) && (buf1_ff == BOM_B) && (req_raw_byte == BOM_C);

   always_comb begin
      lead_done_in   = lead_done_ff;
      lead_cnt_in    = lead_cnt_ff;
      bom_in         = bom_ff;
      push           = 1'b0;
      push_op.bytes  = {req_raw_byte, buf1_ff, buf0_ff};
      push_op.nbytes = 2'd0;
      push_op.tail   = KIND_DATA;
      push_op.bom    = bom_ff;
      if (accept) begin
         if (lead_done_ff) begin
            push = 1'b1;
            if (kind == KIND_DATA) begin
               push_op.bytes  = {buf1_ff, buf0_ff, req_raw_byte};
               push_op.nbytes = 2'd1;
            end else begin
               push_op.tail = kind;
            end
         end else if (kind == KIND_DATA) begin
            if (lead_cnt_ff == 2'd2) begin
               lead_done_in = 1'b1;
               if (bom_match) begin
                  bom_in = 1'b1;
               end else begin
                  push           = 1'b1;
                  push_op.nbytes = 2'd3;
               end
            end else begin
               lead_cnt_in = lead_cnt_ff + 2'd1;
            end
         end else begin
            // mark inside the lead window: release held bytes, then the mark
            lead_done_in   = 1'b1;
            push           = 1'b1;
            push_op.nbytes = lead_cnt_ff;
            push_op.tail   = kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_done_ff <= 1'b0;
         lead_cnt_ff  <= 2'd0;
         bom_ff       <= 1'b0;
      end else begin
         lead_done_ff <= lead_done_in;
         lead_cnt_ff  <= lead_cnt_in;
         bom_ff       <= bom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !lead_done_ff && kind == KIND_DATA) begin
         if (lead_cnt_ff == 2'd0) begin
            buf0_ff <= req_raw_byte;
         end else if (lead_cnt_ff == 2'd1) begin
            buf1_ff <= req_raw_byte;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tin_fifo.sv =====
// Short work queue between front and back end.
`default_nettype none

module tin_fifo import tin_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   output logic   head_valid,
   output op_type head_op,
   input  logic   pop
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   op_type            mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;

   assign full       = (count_ff == CntW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tin_back.sv =====
// Back end: line break folding, whitespace runs, status, result hold and output register.
`default_nettype none

module tin_back import tin_pkg::*; #(
   parameter logic [31:0] RUN_MAX   = RUN_MAX_DEF,
   parameter int          LINE_BITS = LINE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  op_type  head_op,
   output logic    head_pop,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output res_type rsp_res,
   output logic    rsp_last
);

   localparam logic [15:0] RunLimit =
      (RUN_MAX > 32'd65535) ? 16'hffff : RUN_MAX[15:0];
   localparam logic [LINE_BITS-1:0] LineMax = '1;

   typedef enum logic [1:0] {BP_NONE, BP_SKIP_LF, BP_SKIP_CR} brk_type;

   logic [15:0]          tab_ff, tab_in, space_ff, space_in;
   logic [LINE_BITS-1:0] line_ff, line_in, line_inc;
   kind_type             final_ff, final_in;
   brk_type              bp_ff, bp_in;
   logic                 prev_lf_ff, prev_lf_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 hold_v_ff, hold_closed_ff, rsp_valid_ff;
   res_type              hold_ff, rsp_ff;
   logic                 rsp_last_ff;

   logic                 out_free, step_en, produce, done, move, advance;
   logic                 is_mark, last_elem, res_v;
   logic [7:0]           cur_byte, eb;
   res_type              res;
   logic [LINE_BITS+31:0] line_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = head_valid && (!hold_v_ff || out_free);
   assign is_mark   = (idx_ff >= head_op.nbytes);
   assign cur_byte  = head_op.bytes[idx_ff];
   assign last_elem = is_mark ||
                      ((idx_ff == head_op.nbytes - 2'd1) && (head_op.tail == KIND_DATA));
   assign line_inc  = (line_ff == LineMax) ? line_ff : line_ff + LINE_BITS'(1);
   assign eb        = (cur_byte == CH_CR) ? CH_LF : cur_byte;
   assign line_ext  = {32'd0, line_in};

   // One step per cycle while step_en is high; each step yields at most one result.
   always_comb begin
      tab_in     = tab_ff;
      space_in   = space_ff;
      line_in    = line_ff;
      final_in   = final_ff;
      bp_in      = bp_ff;
      prev_lf_in = prev_lf_ff;
      advance    = 1'b0;
      res_v      = 1'b0;
      res.data   = 8'd0;
      res.kind   = KIND_DATA;
      res.count  = 16'd1;
      if (final_ff != STAT_OPEN) begin
         advance = 1'b1;
         if (idx_ff == 2'd0) begin
            res_v    = 1'b1;
            res.kind = final_ff;
         end
      end else if (!is_mark) begin
         if ((bp_ff == BP_SKIP_LF && cur_byte == CH_LF) ||
             (bp_ff == BP_SKIP_CR && cur_byte == CH_CR)) begin
            bp_in   = BP_NONE;
            advance = 1'b1;
         end else begin
            bp_in = (cur_byte == CH_CR) ? BP_SKIP_LF :
                    (cur_byte == CH_LF) ? BP_SKIP_CR : BP_NONE;
            prev_lf_in = (eb == CH_LF);
            case (eb)
               CH_HT: begin
                  advance  = 1'b1;
                  space_in = 16'd0;
                  if (tab_ff >= RunLimit) begin
                     tab_in   = 16'd0;
                     res_v    = 1'b1;
                     res.kind = KIND_ERROR;
                     final_in = KIND_ERROR;
                  end else begin
                     tab_in = tab_ff + 16'd1;
                  end
               end
               CH_SP: begin
                  advance = 1'b1;
                  if (space_ff >= RunLimit) begin
                     tab_in   = 16'd0;
                     space_in = 16'd0;
                     res_v    = 1'b1;
                     res.kind = KIND_ERROR;
                     final_in = KIND_ERROR;
                  end else begin
                     space_in = space_ff + 16'd1;
                  end
               end
               CH_LF: begin
                  advance  = 1'b1;
                  tab_in   = 16'd0;
                  space_in = 16'd0;
                  line_in  = line_inc;
                  res_v    = 1'b1;
                  res.data = CH_LF;
               end
               default: begin
                  // flush pending runs first, one per cycle while stepping
                  res_v = 1'b1;
                  if (tab_ff != 16'd0) begin
                     res.data  = CH_HT;
                     res.count = tab_ff;
                     tab_in    = 16'd0;
                  end else if (space_ff != 16'd0) begin
                     res.data  = CH_SP;
                     res.count = space_ff;
                     space_in  = 16'd0;
                  end else begin
                     res.data = eb;
                     advance  = 1'b1;
                  end
               end
            endcase
         end
      end else if (head_op.tail == KIND_END) begin
         tab_in   = 16'd0;
         space_in = 16'd0;
         res_v    = 1'b1;
         if (!prev_lf_ff) begin
            line_in    = line_inc;
            res.data   = CH_LF;
            prev_lf_in = 1'b1;
         end else begin
            res.kind = KIND_END;
            final_in = KIND_END;
            advance  = 1'b1;
         end
      end else begin
         res_v = 1'b1;
         if (tab_ff != 16'd0) begin
            res.data  = CH_HT;
            res.count = tab_ff;
            tab_in    = 16'd0;
         end else if (space_ff != 16'd0) begin
            res.data  = CH_SP;
            res.count = space_ff;
            space_in  = 16'd0;
         end else begin
            res.kind = KIND_ERROR;
            final_in = KIND_ERROR;
            advance  = 1'b1;
         end
      end
      res.line = line_ext[31:0];
      res.bom  = head_op.bom;
      idx_in   = advance ? (last_elem ? 2'd0 : idx_ff + 2'd1) : idx_ff;
   end

   assign produce  = step_en && res_v;
   assign done     = step_en && advance && last_elem;
   assign head_pop = done;
   // held result leaves on a free output once a later one exists or its item is complete
   assign move     = hold_v_ff && out_free && (hold_closed_ff || produce);

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff         <= 16'd0;
         space_ff       <= 16'd0;
         line_ff        <= LINE_BITS'(1);
         final_ff       <= STAT_OPEN;
         bp_ff          <= BP_NONE;
         prev_lf_ff     <= 1'b0;
         idx_ff         <= 2'd0;
         hold_v_ff      <= 1'b0;
         hold_closed_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (step_en) begin
            tab_ff     <= tab_in;
            space_ff   <= space_in;
            line_ff    <= line_in;
            final_ff   <= final_in;
            bp_ff      <= bp_in;
            prev_lf_ff <= prev_lf_in;
            idx_ff     <= idx_in;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (produce) begin
            hold_v_ff      <= 1'b1;
            hold_closed_ff <= done;
         end else begin
            if (move) begin
               hold_v_ff <= 1'b0;
            end
            if (done) begin
               hold_closed_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         hold_ff <= res;
      end
      if (move) begin
         rsp_ff      <= hold_ff;
         rsp_last_ff <= hold_closed_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/text_input_normalizer.sv =====
// Text input normalizer top level: front end, work queue, back end.
// A word giving one result passes the queue entry, the hold register and the output register before it shows on rsp.
// Throughput: one word per cycle while each word gives at most one result and rsp is not stalled; the
// back-end sequencer emits one result per cycle, so a word with more results holds it until its last result is made.
// Reset: synchronous, active high; clears all control state at once, no clearing pass.
`default_nettype none

module text_input_normalizer import tin_pkg::*; #(
   parameter logic [31:0] RUN_MAX   = RUN_MAX_DEF,
   parameter int          LINE_BITS = LINE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // raw input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_raw_byte,
   input  logic [1:0]  req_raw_kind,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_out_kind,
   output logic [15:0] rsp_repeat_count,
   output logic [31:0] rsp_line_number,
   output logic        rsp_bom_seen,
   output logic        rsp_last_of_run
);

`include "assert_macros.svh"

   logic    q_full, q_push, q_pop, q_head_valid;
   op_type  q_push_op, q_head_op;
   res_type rsp_res;

   // Front: BOM window of three bytes, mark handling, one queue entry per word
   // (or none when the word only fills the window).
   tin_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_raw_byte (req_raw_byte),
      .req_raw_kind (req_raw_kind),
      .q_full       (q_full),
      .push         (q_push),
      .push_op      (q_push_op)
   );

   // Decouples the front from back-end stalls on multi-result words.
   tin_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_op    (q_head_op),
      .pop        (q_pop)
   );

   // Back: CR/LF folding, tab and space runs, line count, sticky status.
   // A one-result hold stage tags the last result of each word before the
   // output register.
   tin_back #(
      .RUN_MAX   (RUN_MAX),
      .LINE_BITS (LINE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_op    (q_head_op),
      .head_pop   (q_pop),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_res    (rsp_res),
      .rsp_last   (rsp_last_of_run)
   );

   assign rsp_out_byte     = rsp_res.data;
   assign rsp_out_kind     = rsp_res.kind;
   assign rsp_repeat_count = rsp_res.count;
   assign rsp_line_number  = rsp_res.line;
   assign rsp_bom_seen     = rsp_res.bom;

   // End and error words carry no byte and a count of one.
   `ASSERT_HOLDS(a_mark_fields, clock, reset, rsp_valid && rsp_out_kind != KIND_DATA |-> rsp_repeat_count == 16'd1 && rsp_out_byte == 8'd0, "mark word with byte or count")
   // Only tab and space runs may repeat.
   `ASSERT_HOLDS(a_run_count, clock, reset, rsp_valid && rsp_out_kind == KIND_DATA && rsp_out_byte != CH_HT && rsp_out_byte != CH_SP |-> rsp_repeat_count == 16'd1, "non-run byte repeated")
   // Repeat count is never zero.
   `ASSERT_NEVER(a_count_zero, clock, reset, rsp_valid && rsp_repeat_count == 16'd0, "zero repeat count")
   // Once a BOM is reported it stays reported on every later word.
   `ASSERT_HOLDS(a_bom_sticky, clock, reset, rsp_valid && rsp_ready && rsp_bom_seen |=> !rsp_valid || rsp_bom_seen, "bom flag dropped")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for text_input_normalizer: directed and random byte streams.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tin_pkg::*;

   // Pending line-break partner: which byte gets swallowed next.
   localparam logic [1:0] BRK_NONE   = 2'd0;
   localparam logic [1:0] BRK_EAT_LF = 2'd1;   // after CR, a following LF is eaten
   localparam logic [1:0] BRK_EAT_CR = 2'd2;   // after LF, a following CR is eaten

   // Longest tab or space run the block may hold.
   localparam int unsigned RUN_CAP = (RUN_MAX_DEF > 32'd65535) ? 65535 : RUN_MAX_DEF;
   localparam logic [63:0] LINE_TOP = (LINE_BITS_DEF >= 64) ? '1 :
                                      ((64'd1 << LINE_BITS_DEF) - 64'd1);
   localparam int MAX_PER_WORD = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int DRAIN_TAIL   = 16;
   localparam int LONG_RUN     = 40;

   typedef enum {RX_FREE, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_type;
   typedef enum {LEAD_BOM, LEAD_NEAR_BOM, LEAD_MIXED, LEAD_MARK} lead_mode_type;
   typedef enum {CLOSE_END_MID, CLOSE_END_AFTER_LF, CLOSE_IO_ERROR,
                 CLOSE_BAD_KIND} close_mode_type;

   // One result word as the bench predicts it.
   typedef struct packed {
      logic [7:0]  data;
      kind_type    kind;
      logic [15:0] count;
      logic [31:0] line;
      logic        bom;
      logic        last_flag;
   } norm_word_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_raw_byte = 8'h00;
   logic [1:0]  req_raw_kind = KIND_DATA;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_out_kind;
   logic [15:0] rsp_repeat_count;
   logic [31:0] rsp_line_number;
   logic        rsp_bom_seen;
   logic        rsp_last_of_run;

   text_input_normalizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_byte     (req_raw_byte),
      .req_raw_kind     (req_raw_kind),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_line_number  (rsp_line_number),
      .rsp_bom_seen     (rsp_bom_seen),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Normalizer prediction state, at its reset values
   // ---------------------------------------------------------------------
   logic [7:0]  lead_bytes [3];
   int          lead_fill     = 0;
   bit          lead_closed   = 1'b0;
   bit          bom_hit       = 1'b0;
   logic [1:0]  pending_break = BRK_NONE;
   bit          prev_lf       = 1'b0;
   int unsigned tab_len       = 0;
   int unsigned space_len     = 0;
   logic [63:0] line_cnt      = 64'd1;
   kind_type    stream_status = STAT_OPEN;

   norm_word_type expected_words [$];   // results still owed by the block, oldest first
   norm_word_type item_words [$];       // results of the word being predicted

   int    failures        = 0;
   int    words_sent      = 0;
   int    results_checked = 0;
   string lead_desc       = "";
   string close_desc      = "";

   // sender burst control
   bit sender_gaps = 1'b1;
   int burst_left  = 1;

   // receiver control; hold_pending is raised by a test, consumed by the receiver
   bit          hold_pending = 1'b0;
   int          hold_left    = 0;
   int          mode_left    = 0;
   rx_mode_type rx_mode      = RX_FREE;
   logic [7:0]  stall_mask   = 8'hff;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void emit(input logic [7:0] b, input kind_type k, input logic [31:0] n);
      norm_word_type w;
      w.data      = b;
      w.kind      = k;
      w.count     = n[15:0];
      w.line      = line_cnt[31:0];
      w.bom       = bom_hit;
      w.last_flag = 1'b0;
      if (item_words.size() < MAX_PER_WORD) item_words.push_back(w);
   endfunction

   function automatic void emit_lf();
      if (line_cnt < LINE_TOP) line_cnt++;
      emit(CH_LF, KIND_DATA, 1);
   endfunction

   function automatic void flush_runs();
      if (tab_len > 0) emit(CH_HT, KIND_DATA, tab_len);
      if (space_len > 0) emit(CH_SP, KIND_DATA, space_len);
      tab_len   = 0;
      space_len = 0;
   endfunction

   function automatic void run_overflow();
      tab_len   = 0;
      space_len = 0;
      emit(8'h00, KIND_ERROR, 1);
      stream_status = KIND_ERROR;
   endfunction

   function automatic void take_byte(input logic [7:0] raw);
      logic [7:0] c;
      c = raw;
      if (stream_status != STAT_OPEN) return;
      // second half of CR+LF or LF+CR
      if (pending_break == BRK_EAT_LF && c == CH_LF) begin
         pending_break = BRK_NONE;
         return;
      end
      if (pending_break == BRK_EAT_CR && c == CH_CR) begin
         pending_break = BRK_NONE;
         return;
      end
      pending_break = BRK_NONE;
      if (c == CH_CR) begin
         c = CH_LF;
         pending_break = BRK_EAT_LF;
      end else if (c == CH_LF) begin
         pending_break = BRK_EAT_CR;
      end
      prev_lf = (c == CH_LF);

      if (c == CH_HT) begin
         space_len = 0;   // spaces before a tab vanish
         if (tab_len >= RUN_CAP) run_overflow();
         else tab_len++;
      end else if (c == CH_SP) begin
         if (space_len >= RUN_CAP) run_overflow();
         else space_len++;
      end else if (c == CH_LF) begin
         tab_len   = 0;   // trailing blanks vanish
         space_len = 0;
         emit_lf();
      end else begin
         flush_runs();
         emit(c, KIND_DATA, 1);
      end
   endfunction

   function automatic void take_mark(input kind_type k);
      if (stream_status != STAT_OPEN) return;
      if (k == KIND_END) begin
         tab_len   = 0;
         space_len = 0;
         if (!prev_lf) begin
            emit_lf();
            prev_lf = 1'b1;
         end
         emit(8'h00, KIND_END, 1);
         stream_status = KIND_END;
      end else begin
         flush_runs();
         emit(8'h00, KIND_ERROR, 1);
         stream_status = KIND_ERROR;
      end
   endfunction

   // Works out the results of one accepted word and queues them.
   function automatic void predict_word(input logic [7:0] b, input kind_type k);
      kind_type      kind_in;
      norm_word_type w;
      kind_in = (k == KIND_BAD) ? KIND_ERROR : k;
      item_words.delete();
      if (stream_status != STAT_OPEN) begin
         emit(8'h00, stream_status, 1);
      end else if (!lead_closed) begin
         if (kind_in == KIND_DATA) begin
            lead_bytes[lead_fill] = b;
            lead_fill++;
            if (lead_fill == 3) begin
               lead_closed = 1'b1;
               if (lead_bytes[0] == BOM_A && lead_bytes[1] == BOM_B && lead_bytes[2] == BOM_C)
                  bom_hit = 1'b1;
               else
                  for (int i = 0; i < 3; i++) take_byte(lead_bytes[i]);
            end
         end else begin
            // mark during lead: release what is held, then the mark
            lead_closed = 1'b1;
            for (int i = 0; i < lead_fill; i++) take_byte(lead_bytes[i]);
            take_mark(kind_in);
         end
      end else if (kind_in == KIND_DATA) begin
         take_byte(b);
      end else begin
         take_mark(kind_in);
      end
      if (item_words.size() > 0) begin
         w = item_words.pop_back();
         w.last_flag = 1'b1;
         item_words.push_back(w);
      end
      foreach (item_words[i]) expected_words.push_back(item_words[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: sampled at the rising edge
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      norm_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: byte %0h kind %0d",
                   rsp_out_byte, rsp_out_kind);
            failures++;
         end else begin
            want = expected_words.pop_front();
            results_checked++;
            check_field("out_byte", want.data, rsp_out_byte);
            check_field("out_kind", want.kind, rsp_out_kind);
            check_field("repeat_count", want.count, rsp_repeat_count);
            check_field("line_number", want.line, rsp_line_number);
            check_field("bom_seen", want.bom, rsp_bom_seen);
            check_field("last_of_run", want.last_flag, rsp_last_of_run);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: picks a new random stall pattern whenever its mode count runs out; a long hold
   // can be requested, counted here
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         rx_mode    = rx_mode_type'($urandom_range(0, 3));
         stall_mask = 8'($urandom);
         mode_left  = int'($urandom_range(16, 96));
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_FREE: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: begin
               rsp_ready <= stall_mask[0];
               stall_mask = {stall_mask[0], stall_mask[7:1]};
            end
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sender: called at a falling edge, returns at a falling edge
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [7:0] b, input kind_type k);
      req_valid    <= 1'b1;
      req_raw_byte <= b;
      req_raw_kind <= k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(b, k);
      words_sent++;
      @(negedge clock);
      if (sender_gaps) begin
         if (burst_left <= 1) begin
            // gap between bursts; payload is junk while valid is low
            req_valid    <= 1'b0;
            req_raw_byte <= 8'($urandom);
            req_raw_kind <= 2'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = int'($urandom_range(1, 20));
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], KIND_DATA);
   endtask

   function automatic logic [7:0] printable();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(8'h80, 8'hff));
      return 8'($urandom_range(8'h21, 8'h7e));
   endfunction

   task automatic send_break();
      case ($urandom_range(0, 5))
         0: send_word(CH_CR, KIND_DATA);
         1: send_word(CH_LF, KIND_DATA);
         2: begin
            send_word(CH_CR, KIND_DATA);
            send_word(CH_LF, KIND_DATA);
         end
         3: begin
            send_word(CH_LF, KIND_DATA);
            send_word(CH_CR, KIND_DATA);
         end
         4: begin
            send_word(CH_CR, KIND_DATA);
            send_word(CH_CR, KIND_DATA);
         end
         default: begin
            send_word(CH_LF, KIND_DATA);
            send_word(CH_LF, KIND_DATA);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // First three bytes: BOM, almost-BOM, mixed bytes, or a mark cutting the lead short.
   task automatic test_lead();
      logic [7:0] pool [8];
      lead_mode_type mode;
      int pick;
      pool = '{BOM_A, BOM_B, BOM_C, CH_CR, CH_LF, CH_HT, CH_SP, 8'h41};
      pick = $urandom_range(0, 7);
      mode = (pick < 3) ? LEAD_BOM : (pick == 3) ? LEAD_NEAR_BOM :
             (pick < 7) ? LEAD_MIXED : LEAD_MARK;
      case (mode)
         LEAD_BOM: begin
            lead_desc = "byte order mark";
            send_word(BOM_A, KIND_DATA);
            send_word(BOM_B, KIND_DATA);
            send_word(BOM_C, KIND_DATA);
         end
         LEAD_NEAR_BOM: begin
            lead_desc = "broken byte order mark";
            send_word(BOM_A, KIND_DATA);
            send_word(BOM_B, KIND_DATA);
            send_word($urandom_range(0, 1) ? 8'hbe : CH_CR, KIND_DATA);
         end
         LEAD_MIXED: begin
            lead_desc = "mixed-byte";
            repeat (3) send_word(pool[$urandom_range(0, 7)], KIND_DATA);
         end
         default: begin
            lead_desc = "mark-truncated";
            repeat ($urandom_range(0, 2)) send_word(pool[$urandom_range(0, 7)], KIND_DATA);
            send_word(8'($urandom), kind_type'($urandom_range(1, 3)));
         end
      endcase
   endtask

   // CR+LF, LF+CR, then CR+LF again (\015 is CR)
   task automatic test_line_breaks();
      send_text("a\015\nb\n\015\015\n");
   endtask

   // space before tab dropped, tab run 2 plus space run 1, trailing blanks before CR dropped
   task automatic test_blanks();
      send_text("x \t\t y  \015");
   endtask

   task automatic test_byte_extremes();
      send_word(8'h00, KIND_DATA);
      send_word(8'hff, KIND_DATA);
   endtask

   // Receiver holds off while the sender keeps pushing: the block must fill and stall req.
   task automatic test_backpressure();
      hold_pending = 1'b1;
      sender_gaps  = 1'b0;
      repeat (60) send_word(printable(), KIND_DATA);
      sender_gaps  = 1'b1;
   endtask

   // Mostly text-like streams: words, blank runs, every kind of line break, some noise.
   task automatic test_random_text(input int target);
      int start;
      int pick;
      start = words_sent;
      while (words_sent - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            repeat ($urandom_range(1, 8)) send_word(printable(), KIND_DATA);
         end else if (pick < 62) begin
            repeat ($urandom_range(1, 6))
               send_word($urandom_range(0, 1) ? CH_HT : CH_SP, KIND_DATA);
         end else if (pick < 87) begin
            send_break();
         end else begin
            send_word(8'($urandom_range(0, 255)), KIND_DATA);
         end
      end
   endtask

   // Long back-to-back blank run flushed by a letter: large repeat count.
   task automatic test_full_run();
      logic [7:0] blank;
      blank = $urandom_range(0, 1) ? CH_HT : CH_SP;
      sender_gaps = 1'b0;
      repeat (LONG_RUN) send_word(blank, KIND_DATA);
      sender_gaps = 1'b1;
      send_word("z", KIND_DATA);
   endtask

   // Close the stream one way; the status sticks from here on.
   task automatic test_close();
      close_mode_type mode;
      mode = close_mode_type'($urandom_range(0, 3));
      case (mode)
         CLOSE_END_MID: begin
            close_desc = "end without a final LF";
            send_text("end");
            send_word(8'h00, KIND_END);
         end
         CLOSE_END_AFTER_LF: begin
            close_desc = "end after an LF";
            send_text("end\n");
            send_word(8'h00, KIND_END);
         end
         CLOSE_IO_ERROR: begin
            close_desc = "I/O error with pending blanks";
            send_text("q \t ");
            send_word(8'h00, KIND_ERROR);
         end
         default: begin
            close_desc = "undefined kind with pending blanks";
            send_text("q \t ");
            send_word(8'($urandom), KIND_BAD);
         end
      endcase
   endtask

   // Every kind after close just repeats the final status.
   task automatic test_after_close();
      for (int i = 0; i < 24; i++) send_word(8'($urandom_range(0, 255)), kind_type'(i[1:0]));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      int wait_cycles;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_lead();
      test_line_breaks();
      test_blanks();
      test_byte_extremes();
      test_backpressure();
      test_random_text(300);
      test_full_run();
      test_close();
      test_after_close();
      req_valid <= 1'b0;

      // let every owed result come out, then keep watching for strays
      wait_cycles = 0;
      while (expected_words.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_TAIL) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected result words never arrived", expected_words.size());
         failures++;
      end

      $display("Covered a %s lead and closing by %s.", lead_desc, close_desc);
      $display("%0d words sent, %0d result words checked, %0d mismatches.",
               words_sent, results_checked, failures);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Run timed out");
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== text_input_normalizer.f =====
+incdir+hdl
hdl/tin_pkg.sv
hdl/tin_front.sv
hdl/tin_fifo.sv
hdl/tin_back.sv
hdl/text_input_normalizer.sv
bench/tb.sv
